@@ hw/rtl/bcs_pkg.sv @@
// Package for the baby_cpu_step core: state, opcode, function and ALU codes,
// the field layout constants and the small decode helpers.
// Used by bcs_alu, baby_cpu_step and the bench; depends on nothing.
package bcs_pkg;

  localparam int unsigned OpShift = 13;
  localparam logic [2:0] OpMaskStd = 3'h7;
  localparam logic [3:0] OpMaskExt = 4'hF;
  localparam logic [5:0] AddrMaskStd = 6'h1F;
  localparam logic [5:0] AddrMaskExt = 6'h3F;
  localparam int unsigned InWidth = 40;
  localparam int unsigned OutWidth = 136;

  typedef enum logic [1:0] {
    FN_STEP  = 2'd0,
    FN_WRITE = 2'd1,
    FN_READ  = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    OP_JMP  = 4'd0,
    OP_JRP  = 4'd1,
    OP_LDN  = 4'd2,
    OP_STO  = 4'd3,
    OP_SUB  = 4'd4,
    OP_SUB2 = 4'd5,
    OP_CMP  = 4'd6,
    OP_STP  = 4'd7,
    OP_ADD  = 4'd8,
    OP_MUL  = 4'd9,
    OP_LDI  = 4'd10,
    OP_NIN  = 4'd11,
    OP_LDX  = 4'd12,
    OP_SBX  = 4'd13,
    OP_NOP0 = 4'd14,
    OP_NOP1 = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC,
    ST_INDIRECT,
    ST_READ,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  function automatic logic [5:0] addr_mask(input logic ext);
    return ext ? AddrMaskExt : AddrMaskStd;
  endfunction

  function automatic op_e decode_op(input logic [31:0] word, input logic ext);
    logic [3:0] code;
    code = ext ? (word[OpShift +: 4] & OpMaskExt) : {1'b0, word[OpShift +: 3] & OpMaskStd};
    return op_e'(code);
  endfunction

  function automatic logic [5:0] operand_of(input logic [31:0] word, input logic ext);
    return word[5:0] & addr_mask(ext);
  endfunction

endpackage

@@ hw/rtl/bcs_alu.sv @@
// Shared arithmetic unit of the baby_cpu_step core: add, subtract and the
// low 32 bits of a multiply. Combinational; the caller registers the result.
// Depends on bcs_pkg.
module bcs_alu (
  input  bcs_pkg::alu_req_t req_i,
  output logic [31:0]       res_o
);
  import bcs_pkg::*;

  always_comb begin
    case (req_i.op)
      ALU_ADD: res_o = req_i.a + req_i.b;
      ALU_SUB: res_o = req_i.a - req_i.b;
      ALU_MUL: res_o = req_i.a * req_i.b;
      default: res_o = req_i.a + req_i.b;
    endcase
  end

endmodule

@@ hw/rtl/baby_cpu_step.sv @@
// Small-scale experimental machine core: one item steps, writes or reads the store.
// A step passes fetch, decode, execute and, for a negative indirect load, indirect states;
// a read passes a read state; halted steps, writes and unused codes go straight to response.
// One item is in work at a time; the next word is taken once the result is loaded.
// Reset clears all but the store, rdata_q and m_data_q; the store reads as zero through per-line valid bits.
// Depends on bcs_pkg and bcs_alu.
module baby_cpu_step #(
  parameter int unsigned STORE_LINES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0: func[1:0], word_address[7:2], write_word[39:8].
  input  logic [bcs_pkg::InWidth-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0: instr_counter[31:0], present_instr[63:32], accum[95:64],
  // index_value[101:96], halted[102], read_word[134:103], zero pad[135].
  output logic [bcs_pkg::OutWidth-1:0]    m_axis_tdata_o
);
  import bcs_pkg::*;

  localparam int unsigned AW = $clog2(STORE_LINES);

  function automatic logic [AW-1:0] line_of(input logic [5:0] v);
    logic [6:0] t;
    t = {1'b0, v};
    if (t >= 7'(STORE_LINES)) begin
      t = t - 7'(STORE_LINES);
    end
    return t[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic        ext_q;
  logic [31:0] ci_q, ci_d;
  logic [31:0] pi_q, pi_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  x_q, x_d;
  logic        halt_q, halt_d;
  logic [31:0] rword_q, rword_d;
  logic        m_valid_q, m_valid_d;
  logic [OutWidth-1:0] m_data_q, m_data_d;

  logic [31:0] mem [STORE_LINES];
  logic [STORE_LINES-1:0] vld_q;
  logic [31:0] rdata_q;
  logic        rvalid_q;
  logic [AW-1:0] raddr, waddr;
  logic        mem_we;
  logic [31:0] wdata;
  logic [31:0] s_word;

  alu_req_t    alu_req;
  logic [31:0] alu_res;

  logic        in_fire;
  func_e       in_func;
  logic [5:0]  in_addr;
  logic [31:0] in_word;
  op_e         dec_op, exe_op;
  logic [5:0]  dec_operand, exe_operand;
  logic        out_free;

  bcs_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign in_func = func_e'(s_axis_tdata_i[1:0]);
  assign in_addr = s_axis_tdata_i[7:2];
  assign in_word = s_axis_tdata_i[39:8];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o = m_data_q;

  assign s_word = rvalid_q ? rdata_q : 32'd0;
  assign dec_op = decode_op(s_word, ext_q);
  assign dec_operand = operand_of(s_word, ext_q);
  assign exe_op = decode_op(pi_q, ext_q);
  assign exe_operand = operand_of(pi_q, ext_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_STEP:  state_d = halt_q ? ST_RESP : ST_FETCH;
            FN_READ:  state_d = ST_READ;
            default:  state_d = ST_RESP;
          endcase
        end
      end
      ST_FETCH:    state_d = ST_DECODE;
      ST_DECODE:   state_d = ST_EXEC;
      ST_EXEC:     state_d = (exe_op == OP_NIN) ? ST_INDIRECT : ST_RESP;
      ST_INDIRECT: state_d = ST_RESP;
      ST_READ:     state_d = ST_RESP;
      ST_RESP:     state_d = out_free ? ST_IDLE : ST_RESP;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a = ci_q;
    alu_req.b = 32'd1;
    case (state_q)
      ST_EXEC: begin
        case (exe_op)
          OP_JRP: alu_req.b = s_word;
          OP_LDN: begin
            alu_req.op = ALU_SUB;
            alu_req.a = 32'd0;
            alu_req.b = s_word;
          end
          OP_SUB, OP_SUB2, OP_SBX: begin
            alu_req.op = ALU_SUB;
            alu_req.a = acc_q;
            alu_req.b = s_word;
          end
          OP_ADD: begin
            alu_req.a = acc_q;
            alu_req.b = s_word;
          end
          OP_MUL: begin
            alu_req.op = ALU_MUL;
            alu_req.a = acc_q;
            alu_req.b = s_word;
          end
          default: ;
        endcase
      end
      ST_INDIRECT: begin
        alu_req.op = ALU_SUB;
        alu_req.a = 32'd0;
        alu_req.b = s_word;
      end
      default: ;
    endcase
  end

  always_comb begin
    ci_d = ci_q;
    pi_d = pi_q;
    acc_d = acc_q;
    x_d = x_q;
    halt_d = halt_q;
    rword_d = rword_q;
    raddr = '0;
    waddr = line_of(in_addr & addr_mask(ext_q));
    wdata = in_word;
    mem_we = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d = m_data_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rword_d = 32'd0;
          raddr = line_of(in_addr & addr_mask(ext_q));
          if (in_func == FN_STEP && !halt_q) begin
            ci_d = alu_res;
          end
          if (in_func == FN_WRITE) begin
            mem_we = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        raddr = line_of(ci_q[5:0] & addr_mask(ext_q));
      end
      ST_DECODE: begin
        pi_d = s_word;
        if (dec_op == OP_SBX) begin
          raddr = line_of((dec_operand + x_q) & addr_mask(ext_q));
        end else begin
          raddr = line_of(dec_operand);
        end
      end
      ST_EXEC: begin
        case (exe_op)
          OP_JMP: ci_d = s_word;
          OP_JRP: ci_d = alu_res;
          OP_LDN: acc_d = alu_res;
          OP_STO: begin
            mem_we = 1'b1;
            waddr = line_of(exe_operand);
            wdata = acc_q;
          end
          OP_SUB, OP_SUB2, OP_SBX: acc_d = alu_res;
          OP_CMP: begin
            if (acc_q[31]) begin
              ci_d = alu_res;
            end
          end
          OP_STP: halt_d = 1'b1;
          OP_ADD: acc_d = alu_res;
          OP_MUL: acc_d = alu_res;
          OP_LDI: acc_d = {26'd0, exe_operand};
          OP_NIN: raddr = line_of(s_word[5:0] & addr_mask(ext_q));
          OP_LDX: x_d = exe_operand;
          default: ;
        endcase
      end
      ST_INDIRECT: begin
        acc_d = alu_res;
      end
      ST_READ: begin
        rword_d = s_word;
      end
      ST_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d = {1'b0, rword_q, halt_q, x_q, acc_q, pi_q, ci_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ext_q <= 1'b0;
      ci_q <= '0;
      pi_q <= '0;
      acc_q <= '0;
      x_q <= '0;
      halt_q <= 1'b0;
      rword_q <= '0;
      m_valid_q <= 1'b0;
      vld_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ext_q <= cfg_wdata_i;
      end
      ci_q <= ci_d;
      pi_q <= pi_d;
      acc_q <= acc_d;
      x_q <= x_d;
      halt_q <= halt_d;
      rword_q <= rword_d;
      m_valid_q <= m_valid_d;
      if (mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      rvalid_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

@@ verif/tb.sv @@
// Self-checking bench for baby_cpu_step: a directed table, then random programs and noise, then a closing halt.
// Results are checked against a predictor kept inside this bench, or against results carried by directed rows.
// Depends on bcs_pkg and the baby_cpu_step RTL.
`timescale 1ns / 100ps

module tb;
  import bcs_pkg::*;

  typedef struct packed {
    logic [31:0] ci;
    logic [31:0] pi;
    logic [31:0] acc;
    logic [5:0]  x;
    logic        halt;
    logic [31:0] rd;
  } regs_t;

  typedef struct {
    func_e       fn;
    logic [5:0]  addr;
    logic [31:0] data;
    bit          typed;
    logic [31:0] rd;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InWidth-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;

  logic [31:0] mdl_store [64] = '{default: '0};
  logic [31:0] mdl_ci = '0;
  logic [31:0] mdl_pi = '0;
  logic [31:0] mdl_acc = '0;
  logic [5:0]  mdl_x = '0;
  logic        mdl_halt = 1'b0;
  logic        mdl_ext = 1'b0;
  logic [15:0] op_seen = '0;

  regs_t exp_regs_q [$];
  int    snd_pct = 0;
  int    rcv_pct = 0;
  int    snd_tab [4] = '{0, 61, 0, 22};
  int    rcv_tab [4] = '{0, 0, 61, 22};
  int    n_sent = 0;
  int    n_steps = 0;
  int    n_checked = 0;
  int    n_err = 0;

  baby_cpu_step u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still outstanding.", exp_regs_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [5:0] line_at(input logic [31:0] a);
    return a[5:0] & (mdl_ext ? AddrMaskExt : AddrMaskStd);
  endfunction

  function automatic logic [3:0] op_of(input logic [31:0] w);
    return mdl_ext ? w[OpShift +: 4] : {1'b0, w[OpShift +: 3]};
  endfunction

  function automatic logic [31:0] make_instr(input op_e op, input logic [5:0] opnd);
    return (32'(op) << OpShift) | 32'(opnd);
  endfunction

  function automatic logic [31:0] rand_data();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Any opcode of the current mode except stop, with random operand and spare bits.
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [3:0]  op;
    w = $urandom;
    do op = 4'($urandom_range(mdl_ext ? 15 : 6)); while (op == OP_STP);
    if (mdl_ext) begin
      w[OpShift +: 4] = op;
    end else begin
      w[OpShift +: 3] = op[2:0];
    end
    return w;
  endfunction

  function automatic regs_t machine_next(input func_e fn, input logic [5:0] addr,
                                         input logic [31:0] data);
    regs_t       r;
    logic [5:0]  opnd;
    logic [31:0] s;
    logic [3:0]  code;
    r.rd = '0;
    case (fn)
      FN_STEP: if (!mdl_halt) begin
        mdl_ci = mdl_ci + 32'd1;
        mdl_pi = mdl_store[line_at(mdl_ci)];
        opnd = line_at(mdl_pi);
        code = op_of(mdl_pi);
        s = mdl_store[opnd];
        op_seen[code] = 1'b1;
        case (op_e'(code))
          OP_JMP: mdl_ci = s;
          OP_JRP: mdl_ci = mdl_ci + s;
          OP_LDN: mdl_acc = 32'd0 - s;
          OP_STO: mdl_store[opnd] = mdl_acc;
          OP_SUB, OP_SUB2: mdl_acc = mdl_acc - s;
          OP_CMP: if (mdl_acc[31]) begin
            mdl_ci = mdl_ci + 32'd1;
          end
          OP_STP: mdl_halt = 1'b1;
          OP_ADD: mdl_acc = mdl_acc + s;
          OP_MUL: mdl_acc = mdl_acc * s;
          OP_LDI: mdl_acc = 32'(opnd);
          OP_NIN: mdl_acc = 32'd0 - mdl_store[line_at(s)];
          OP_LDX: mdl_x = opnd;
          OP_SBX: mdl_acc = mdl_acc - mdl_store[line_at(32'(6'(opnd + mdl_x)))];
          default: ;
        endcase
      end
      FN_WRITE: mdl_store[line_at(32'(addr))] = data;
      FN_READ: r.rd = mdl_store[line_at(32'(addr))];
      default: ;
    endcase
    r.ci = mdl_ci;
    r.pi = mdl_pi;
    r.acc = mdl_acc;
    r.x = mdl_x;
    r.halt = mdl_halt;
    return r;
  endfunction

  task automatic send_word(input func_e fn, input logic [5:0] addr, input logic [31:0] data,
                           input bit typed, input logic [31:0] typed_rd);
    regs_t want;
    int    gap;
    s_tdata <= {data, addr, fn};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    want = machine_next(fn, addr, data);
    if (typed) begin
      want = '0;
      want.rd = typed_rd;
    end
    exp_regs_q.push_back(want);
    n_sent++;
    if (fn == FN_STEP) begin
      n_steps++;
    end
    gap = 0;
    while (gap < 12 && $urandom_range(99) < snd_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (exp_regs_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_ext = m;
  endtask

  // A stop must only run in the closing sequence, so a stop word about to be
  // fetched is overwritten first.
  task automatic step_guarded();
    logic [5:0] nxt;
    nxt = line_at(mdl_ci + 32'd1);
    if (op_of(mdl_store[nxt]) == OP_STP) begin
      send_word(FN_WRITE, nxt, rand_instr(), 1'b0, '0);
    end
    send_word(FN_STEP, 6'($urandom), $urandom, 1'b0, '0);
  endtask

  task automatic run_program();
    int          n;
    logic [31:0] w;
    n = $urandom_range(2, 6);
    for (int k = 1; k <= n; k++) begin
      w = rand_instr();
      if ($urandom_range(99) < 60) begin
        send_word(FN_WRITE, w[5:0], rand_data(), 1'b0, '0);
      end
      send_word(FN_WRITE, line_at(mdl_ci + 32'(k)), w, 1'b0, '0);
    end
    for (int k = 0; k <= n; k++) step_guarded();
  endtask

  task automatic noise_item();
    func_e fn;
    fn = func_e'($urandom_range(3));
    if (fn == FN_STEP) begin
      step_guarded();
    end else begin
      send_word(fn, 6'($urandom), rand_data(), 1'b0, '0);
    end
  endtask

  task automatic check_word(input regs_t got);
    regs_t want;
    if (exp_regs_q.size() == 0) begin
      n_err++;
      if (n_err <= 10) begin
        $display("%0t: result word arrived with nothing expected, ci=%h", $realtime, got.ci);
      end
    end else begin
      want = exp_regs_q.pop_front();
      n_checked++;
      if (got !== want) begin
        n_err++;
        if (n_err <= 10) begin
          $display("%0t: mismatch on result %0d", $realtime, n_checked);
          $display("  expected ci=%h pi=%h acc=%h x=%h halt=%b rd=%h",
                   want.ci, want.pi, want.acc, want.x, want.halt, want.rd);
          $display("  actual   ci=%h pi=%h acc=%h x=%h halt=%b rd=%h",
                   got.ci, got.pi, got.acc, got.x, got.halt, got.rd);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_pct);
    if (m_tvalid && m_tready) begin
      check_word(regs_t'({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                          m_tdata[101:96], m_tdata[102], m_tdata[134:103]}));
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    int       stop_at;
    bit       paused;

    // Registers stay zero until the first step, so those rows carry their result.
    dir_tab.push_back(dir_row_t'{FN_READ, 6'd0, 32'd0, 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_NONE, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_READ, 6'd31, 32'd0, 1'b1, 32'hFFFF_FFFF});
    dir_tab.push_back(dir_row_t'{FN_READ, 6'd63, 32'd0, 1'b1, 32'hFFFF_FFFF});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd20, 32'h8000_0000, 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd21, 32'd1, 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd23, 32'd10, 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd1, make_instr(OP_LDN, 6'd20), 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd2, make_instr(OP_CMP, 6'd0), 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd4, make_instr(OP_SUB, 6'd21), 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd5, make_instr(OP_STO, 6'd22), 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd6, make_instr(OP_JRP, 6'd21), 1'b1, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_WRITE, 6'd8, make_instr(OP_JMP, 6'd23), 1'b1, 32'd0});
    repeat (7) dir_tab.push_back(dir_row_t'{FN_STEP, 6'd63, 32'hFFFF_FFFF, 1'b0, 32'd0});
    dir_tab.push_back(dir_row_t'{FN_READ, 6'd22, 32'd0, 1'b0, 32'd0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_word(dir_tab[i].fn, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].typed,
                dir_tab[i].rd);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      snd_pct = snd_tab[ph / 2];
      rcv_pct = rcv_tab[ph / 2];
      set_mode(1'(ph % 2));
      paused = 1'b0;
      stop_at = n_sent + 150;
      while (n_sent < stop_at) begin
        if (!paused && n_sent >= stop_at - 75) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 75) begin
          run_program();
        end else begin
          noise_item();
        end
      end
    end

    // Closing sequence: halt the machine, then show that steps freeze while
    // store writes and reads still work.
    send_word(FN_WRITE, line_at(mdl_ci + 32'd1), make_instr(OP_STP, 6'd0), 1'b0, '0);
    repeat (3) send_word(FN_STEP, 6'($urandom), $urandom, 1'b0, '0);
    send_word(FN_WRITE, 6'd5, 32'hA5A5_5A5A, 1'b0, '0);
    send_word(FN_READ, 6'd5, 32'd0, 1'b0, '0);
    send_word(FN_NONE, 6'd5, 32'd0, 1'b0, '0);
    send_word(FN_STEP, 6'd0, 32'd0, 1'b0, '0);
    drain();
    repeat (12) @(posedge clk);

    $display("Sent %0d words (%0d steps) over eight phases in both store modes, %0d checked.",
             n_sent, n_steps, n_checked);
    $display("Executed %0d of 16 opcodes; %0d mismatches found.", $countones(op_seen), n_err);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
